// File: rtl/box_frustum_cull_defines.svh
// Assertion macros used by the checker file of the box frustum cull block.
`ifndef BOX_FRUSTUM_CULL_DEFINES_SVH
`define BOX_FRUSTUM_CULL_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define BFC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("box_frustum_cull check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define BFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("box_frustum_cull check failed");

`endif

// File: rtl/bfc_pkg.sv
// Shared constants, types and helper functions of the box frustum cull block.
package bfc_pkg;

	// Block configuration. COORD_BITS may not exceed the field width.
	localparam int PLANE_COUNT = 4;
	localparam int COORD_BITS  = 16;

	// Fixed formats.
	localparam int FIELD_W     = 16;
	localparam int NORM_W      = 16;
	localparam int NORM_FRAC   = 14;
	localparam int AXES        = 3;
	localparam int PLANE_REGS  = 4;
	localparam int PLANE_IDX_W = $clog2(PLANE_REGS);
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = AXES * NORM_W;
	localparam int PROD_W      = NORM_W + COORD_BITS;
	localparam int DOT_W       = PROD_W + 2;
	localparam int PIPE_DEPTH  = 3;

	// Register map.
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_NORMAL_BASE = cfg_idx_t'(0);
	localparam cfg_idx_t REG_OFFSET_BASE = cfg_idx_t'(PLANE_REGS);
	localparam cfg_idx_t REG_END         = cfg_idx_t'(2 * PLANE_REGS);

	typedef logic [CFG_DATA_W-1:0]    cfg_data_t;
	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [NORM_W-1:0]  norm_t;
	typedef logic signed [COORD_BITS-1:0] offset_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [DOT_W-1:0]   dot_t;

	// One plane as the datapath sees it.
	typedef struct packed {
		norm_t   nz;
		norm_t   ny;
		norm_t   nx;
		offset_t off;
	} plane_t;

	// Low COORD_BITS of a field, read as two's complement.
	function automatic coord_t to_coord(field_t f);
		return coord_t'(f[COORD_BITS-1:0]);
	endfunction

	// Normal component of one axis: 0 is x, 1 is y, 2 is z.
	function automatic norm_t norm_axis(plane_t pl, int unsigned axis);
		norm_t n;
		unique case (axis)
			0:       n = pl.nx;
			1:       n = pl.ny;
			default: n = pl.nz;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/bfc_cfg_regs.sv
// Plane configuration registers: normals and offsets, written through the config channel.
module bfc_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  bfc_pkg::cfg_idx_t    cfg_index,
	input  bfc_pkg::cfg_data_t   cfg_data,
	output bfc_pkg::plane_t      planes [bfc_pkg::PLANE_COUNT]
);
	import bfc_pkg::*;

	logic [CFG_DATA_W-1:0] normal_q [PLANE_REGS];
	logic [FIELD_W-1:0]    offset_q [PLANE_REGS];
	logic [CFG_IDX_W-1:0]  offset_idx;

	// Writes never stall.
	assign cfg_ready  = 1'b1;
	assign offset_idx = cfg_index - REG_OFFSET_BASE;

	// Register write decode; indexes past the map are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_REGS; i++) begin
				normal_q[i] <= '0;
				offset_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			priority if (cfg_index < REG_OFFSET_BASE) begin
				normal_q[cfg_index[PLANE_IDX_W-1:0]] <= cfg_data;
			end else if (cfg_index < REG_END) begin
				offset_q[offset_idx[PLANE_IDX_W-1:0]] <= cfg_data[FIELD_W-1:0];
			end else begin
				// An index past the map leaves every register as it is.
			end
		end
	end

	// Unpack the tested planes.
	always_comb begin
		for (int p = 0; p < PLANE_COUNT; p++) begin
			planes[p].nx  = norm_t'(normal_q[p][NORM_W-1:0]);
			planes[p].ny  = norm_t'(normal_q[p][2*NORM_W-1:NORM_W]);
			planes[p].nz  = norm_t'(normal_q[p][3*NORM_W-1:2*NORM_W]);
			planes[p].off = offset_t'(offset_q[p][COORD_BITS-1:0]);
		end
	end

endmodule

// File: rtl/bfc_corner_sel.sv
// Stage 1: per plane and axis, picks the box coordinate that maximizes the dot product.
module bfc_corner_sel (
	input  logic             clk,
	input  logic             arst_n,
	input  bfc_pkg::plane_t  planes [bfc_pkg::PLANE_COUNT],
	input  bfc_pkg::coord_t  lo [bfc_pkg::AXES],
	input  bfc_pkg::coord_t  hi [bfc_pkg::AXES],
	input  logic             in_valid,
	output logic             in_ready,
	output bfc_pkg::coord_t  sel_s1 [bfc_pkg::PLANE_COUNT][bfc_pkg::AXES],
	output logic             valid_s1,
	input  logic             out_ready
);
	import bfc_pkg::*;

	logic pick_hi [PLANE_COUNT][AXES];

	// A stage takes an item when empty or when its item moves on.
	assign in_ready = !valid_s1 || out_ready;

	// The best corner takes the larger coordinate for a non-negative normal
	// component and the smaller one otherwise; swapped corners need no care.
	always_comb begin
		for (int p = 0; p < PLANE_COUNT; p++) begin
			for (int a = 0; a < AXES; a++) begin
				pick_hi[p][a] = (norm_axis(planes[p], a) >= 0) == (hi[a] >= lo[a]);
			end
		end
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				for (int a = 0; a < AXES; a++) begin
					sel_s1[p][a] <= pick_hi[p][a] ? hi[a] : lo[a];
				end
			end
		end
	end

endmodule

// File: rtl/bfc_dot_mul.sv
// Stage 2: exact products of each normal component with its selected coordinate.
module bfc_dot_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  bfc_pkg::plane_t  planes [bfc_pkg::PLANE_COUNT],
	input  bfc_pkg::coord_t  sel_s1 [bfc_pkg::PLANE_COUNT][bfc_pkg::AXES],
	input  logic             valid_s1,
	output logic             in_ready,
	output bfc_pkg::prod_t   prod_s2 [bfc_pkg::PLANE_COUNT][bfc_pkg::AXES],
	output logic             valid_s2,
	input  logic             out_ready
);
	import bfc_pkg::*;

	assign in_ready = !valid_s2 || out_ready;

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// One 16 by COORD_BITS signed multiply per plane and axis.
	always_ff @(posedge clk) begin
		if (valid_s1 && in_ready) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				for (int a = 0; a < AXES; a++) begin
					prod_s2[p][a] <= prod_t'(norm_axis(planes[p], a)) * prod_t'(sel_s1[p][a]);
				end
			end
		end
	end

endmodule

// File: rtl/bfc_plane_cmp.sv
// Stage 3: sums the products, compares against each offset and merges the planes.
module bfc_plane_cmp (
	input  logic             clk,
	input  logic             arst_n,
	input  bfc_pkg::plane_t  planes [bfc_pkg::PLANE_COUNT],
	input  bfc_pkg::prod_t   prod_s2 [bfc_pkg::PLANE_COUNT][bfc_pkg::AXES],
	input  logic             valid_s2,
	output logic             in_ready,
	output logic             outside_s3,
	output logic             valid_s3,
	input  logic             out_ready
);
	import bfc_pkg::*;

	dot_t                   dot   [PLANE_COUNT];
	dot_t                   limit [PLANE_COUNT];
	logic [PLANE_COUNT-1:0] behind;

	assign in_ready = !valid_s3 || out_ready;

	// The best corner is behind a plane when its dot product does not exceed
	// the offset scaled to Q1.14; then no corner is in front.
	always_comb begin
		for (int p = 0; p < PLANE_COUNT; p++) begin
			dot[p] = '0;
			for (int a = 0; a < AXES; a++) begin
				dot[p] = dot[p] + dot_t'(prod_s2[p][a]);
			end
			limit[p]  = dot_t'(planes[p].off) <<< NORM_FRAC;
			behind[p] = dot[p] <= limit[p];
		end
	end

	// Stage valid; this stage is the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= valid_s2;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (valid_s2 && in_ready) begin
			outside_s3 <= |behind;
		end
	end

endmodule

// File: rtl/box_frustum_cull.sv
// Top level of the box frustum cull block: config registers and the three-stage test pipeline.
// The block takes one box per clock cycle unless a stall holds its first stage. Each box passes
// three register stages, corner selection, the twelve 16-bit multiplies, and the sum with
// offset compare. The stages advance independently, so a stalled result only holds the stages
// behind it while they are full. Planes are written through the config channel, which never
// stalls; the user must write them only while no item is in flight, and the block does not
// enforce it. After reset every plane is zero and every box reports outside.
module box_frustum_cull (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  bfc_pkg::cfg_idx_t   cfg_index,
	input  bfc_pkg::cfg_data_t  cfg_data,
	input  logic                box_valid,
	output logic                box_ready,
	input  bfc_pkg::field_t     min_x,
	input  bfc_pkg::field_t     min_y,
	input  bfc_pkg::field_t     min_z,
	input  bfc_pkg::field_t     max_x,
	input  bfc_pkg::field_t     max_y,
	input  bfc_pkg::field_t     max_z,
	output logic                res_valid,
	input  logic                res_ready,
	output logic                outside
);
	import bfc_pkg::*;

	plane_t planes [PLANE_COUNT];
	coord_t lo [AXES];
	coord_t hi [AXES];
	coord_t sel_s1 [PLANE_COUNT][AXES];
	prod_t  prod_s2 [PLANE_COUNT][AXES];
	logic   valid_s1;
	logic   valid_s2;
	logic   mul_ready;
	logic   cmp_ready;

	// Box corners trimmed to the coordinate width.
	assign lo[0] = to_coord(min_x);
	assign lo[1] = to_coord(min_y);
	assign lo[2] = to_coord(min_z);
	assign hi[0] = to_coord(max_x);
	assign hi[1] = to_coord(max_y);
	assign hi[2] = to_coord(max_z);

	bfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes)
	);

	bfc_corner_sel u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.planes    (planes),
		.lo        (lo),
		.hi        (hi),
		.in_valid  (box_valid),
		.in_ready  (box_ready),
		.sel_s1    (sel_s1),
		.valid_s1  (valid_s1),
		.out_ready (mul_ready)
	);

	bfc_dot_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.planes    (planes),
		.sel_s1    (sel_s1),
		.valid_s1  (valid_s1),
		.in_ready  (mul_ready),
		.prod_s2   (prod_s2),
		.valid_s2  (valid_s2),
		.out_ready (cmp_ready)
	);

	bfc_plane_cmp u_cmp (
		.clk        (clk),
		.arst_n     (arst_n),
		.planes     (planes),
		.prod_s2    (prod_s2),
		.valid_s2   (valid_s2),
		.in_ready   (cmp_ready),
		.outside_s3 (outside),
		.valid_s3   (res_valid),
		.out_ready  (res_ready)
	);

endmodule

// File: rtl/bfc_port_checker.sv
// Port-level checks of the box frustum cull block, bound to its top level.
`include "box_frustum_cull_defines.svh"

module bfc_port_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                box_valid,
	input logic                box_ready,
	input logic                res_valid,
	input logic                res_ready,
	input logic                outside
);
	import bfc_pkg::*;

	localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

	logic [CNT_W-1:0] inflight_q;
	logic             box_acc;
	logic             res_acc;

	assign box_acc = box_valid && box_ready;
	assign res_acc = res_valid && res_ready;

	// Items accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(box_acc) - CNT_W'(res_acc);
		end
	end

	// A result only shows for an item that was taken in.
	`BFC_ASSERT_IMPL(a_no_phantom, res_valid, inflight_q != '0)
	// The pipeline never holds more items than it has stages.
	`BFC_ASSERT_IMPL(a_depth, 1'b1, inflight_q <= CNT_W'(PIPE_DEPTH))
	// With the output stage empty, nothing can hold the input back.
	`BFC_ASSERT_IMPL(a_ready_when_drained, !res_valid, box_ready)
	// A stalled result holds its flag.
	`BFC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(outside))

endmodule

bind box_frustum_cull bfc_port_checker u_port_checker (.*);
